// ===== src/wgm_pkg.sv =====
// Shared constants and types for the wildcard glob matcher.
`default_nettype none

package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int SYM_W           = 8;

    localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [SYM_W-1:0] ANY_BYTE  = 8'h3F;

    typedef struct packed {
        logic             text_step;
        logic             use_empty;
        logic             wr_en;
        logic             wr_lead;
        logic [SYM_W-1:0] sym;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/wgm_cell.sv =====
// One pattern position: stored byte, leading-star mark and its match bit.
`default_nettype none

module wgm_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 7
) (
    input  wire                      aclk,
    input  wire wgm_pkg::cell_ctrl_t ctrl,
    input  wire  [LEN_W-1:0]         len,
    input  wire  [LEN_W-1:0]         wr_idx,
    input  wire                      prev_next,
    input  wire                      left_cur,
    output logic                     next_out,
    output logic                     cur_out,
    output logic                     last_hit
);

    logic [wgm_pkg::SYM_W-1:0] pat_reg;
    logic                      lead_reg;
    logic                      row_reg;

    logic active;
    logic is_last;
    logic is_star;
    logic sym_hit;

    always_comb begin
        active   = LEN_W'(IDX) < len;
        is_last  = LEN_W'(IDX + 1) == len;
        is_star  = pat_reg == wgm_pkg::STAR_BYTE;
        sym_hit  = (pat_reg == wgm_pkg::ANY_BYTE) || (pat_reg == ctrl.sym);
        cur_out  = ctrl.use_empty ? (active & lead_reg) : row_reg;
        next_out = active & (is_star ? (prev_next | cur_out) : (sym_hit & left_cur));
        last_hit = is_last & next_out;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.text_step) begin
            row_reg <= next_out;
        end
        if (ctrl.wr_en && (wr_idx == LEN_W'(IDX))) begin
            pat_reg  <= ctrl.sym;
            lead_reg <= ctrl.wr_lead;
        end
    end

endmodule

`default_nettype wire

// ===== src/wgm_row.sv =====
// Row of pattern cells chained through the match recurrence.
`default_nettype none

module wgm_row #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
    parameter int LEN_W       = 7
) (
    input  wire                      aclk,
    input  wire wgm_pkg::cell_ctrl_t ctrl,
    input  wire  [LEN_W-1:0]         len,
    input  wire  [LEN_W-1:0]         wr_idx,
    output logic                     hit
);

    logic [MAX_PATTERN:0]   next_chain;
    logic [MAX_PATTERN:0]   cur_chain;
    logic [MAX_PATTERN-1:0] last_hits;

    // entry zero: set in the empty-text row, cleared by any text byte
    assign next_chain[0] = 1'b0;
    assign cur_chain[0]  = ctrl.use_empty;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        wgm_cell #(
            .IDX   (k),
            .LEN_W (LEN_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .len       (len),
            .wr_idx    (wr_idx),
            .prev_next (next_chain[k]),
            .left_cur  (cur_chain[k]),
            .next_out  (next_chain[k+1]),
            .cur_out   (cur_chain[k+1]),
            .last_hit  (last_hits[k])
        );
    end

    assign hit = |last_hits;

endmodule

`default_nettype wire

// ===== src/wildcard_glob_matcher.sv =====
// Top level of the wildcard glob matcher: stream ports, pattern control, output register.
//
// Input beats carry a pattern byte (tuser[0] = 0) or a text byte (tuser[0] = 1) in
// s_tdata; tuser[1] marks the first byte of a new pattern or a new text. '*' matches
// any run of bytes, '?' any one byte. Every input beat yields one output beat:
// m_tdata[0] says whether the text so far matches the whole pattern (for a pattern
// beat, the empty text), m_tdata[1] is the sticky flag that a pattern byte was
// dropped because all MAX_PATTERN cells were full.
// One beat per cycle is accepted while s_tready is high; the whole cell row updates in the
// accepting cycle through the neighbor-to-neighbor star chain, and the result appears in the
// output register in the cycle after acceptance. The output register lets a new beat in while
// the held result is taken in the same cycle; while the receiver stalls with a result
// held, s_tready is low. Reset (aresetn low, synchronous) empties the pattern, clears
// the overflow flag and the output valid flag (the output data is not reset); stored
// pattern bytes are not cleared and are never read before they are written.
`default_nettype none

module wildcard_glob_matcher #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] symbol
    input  wire  [1:0]  s_tuser,   // [0] action, [1] first
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata    // [0] matched, [1] overflow, [7:2] zero
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] ls_reg, ls_next;
    logic             ov_reg, ov_next;
    logic             fresh_reg, fresh_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_data_reg, m_data_next;

    logic             accept;
    logic             action;
    logic             first;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] ls_eff;
    logic             ov_eff;
    logic             room;
    logic             lead;
    logic             hit;

    wgm_pkg::cell_ctrl_t ctrl;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign action   = s_tuser[0];
    assign first    = s_tuser[1];

    always_comb begin
        len_eff = first ? '0 : len_reg;
        ls_eff  = first ? '0 : ls_reg;
        ov_eff  = first ? 1'b0 : ov_reg;
        room    = len_eff < LEN_W'(MAX_PATTERN);
        lead    = (s_tdata == wgm_pkg::STAR_BYTE) && (ls_eff == len_eff);

        ctrl.text_step = accept && action;
        ctrl.use_empty = fresh_reg || first;
        ctrl.wr_en     = accept && !action && room;
        ctrl.wr_lead   = lead;
        ctrl.sym       = s_tdata;
    end

    wgm_row #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_row (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .len    (len_reg),
        .wr_idx (len_eff),
        .hit    (hit)
    );

    always_comb begin
        len_next     = len_reg;
        ls_next      = ls_reg;
        ov_next      = ov_reg;
        fresh_next   = fresh_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (accept) begin
            m_valid_next = 1'b1;
            if (!action) begin
                len_next   = room ? len_eff + LEN_W'(1) : len_eff;
                ls_next    = (room && lead) ? ls_eff + LEN_W'(1) : ls_eff;
                ov_next    = room ? ov_eff : 1'b1;
                fresh_next = 1'b1;
                // empty text matches only an all-star pattern
                m_data_next = {ov_next, ls_next == len_next};
            end else begin
                fresh_next  = 1'b0;
                m_data_next = {ov_reg, hit};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            ls_reg      <= '0;
            ov_reg      <= 1'b0;
            fresh_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            ls_reg      <= ls_next;
            ov_reg      <= ov_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_data_reg};

`ifndef ASSERT_OFF
    a_ls_le_len: assert property (@(posedge aclk) disable iff (!aresetn)
        ls_reg <= len_reg)
        else $error("leading star count exceeds pattern length");

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_first_clears_ov: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !action && first |=> m_tvalid && !m_tdata[1])
        else $error("new pattern did not clear overflow");

    a_text_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && action |=> m_tvalid && !fresh_reg)
        else $error("text beat left empty-row state set");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for wildcard_glob_matcher: random streams checked against a cycle-free glob predictor.
`timescale 1ns / 1ps

module tb;

    localparam int MAXP = wgm_pkg::MAX_PATTERN_DEF;

    typedef enum logic { ACT_PATTERN = 1'b0, ACT_TEXT = 1'b1 } action_e;
    typedef enum int { RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE } rx_mode_e;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic [1:0] s_tuser  = '0;   // [0] action, [1] first
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [0] matched, [1] overflow, [7:2] zero

    // predicted glob state
    logic [7:0]  pat_mem [MAXP];
    int          pat_len;
    int          lead_stars;
    logic [MAXP:0] dp_row;
    logic        ovf_seen;

    verdict_t verdict_q [$];
    int       mismatch_count = 0;
    int       burst_left = 0;

    wildcard_glob_matcher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void load_empty_row();
        int j;
        for (j = 0; j <= MAXP; j++) begin
            dp_row[j] = (j <= lead_stars) && (j <= pat_len);
        end
    endfunction

    function automatic verdict_t glob_step(action_e act, logic [7:0] sym, logic first);
        logic [MAXP:0] nxt;
        int            j;
        verdict_t      v;
        if (act == ACT_PATTERN) begin
            if (first) begin
                pat_len    = 0;
                lead_stars = 0;
                ovf_seen   = 1'b0;
            end
            if (pat_len < MAXP) begin
                pat_mem[pat_len] = sym;
                if (sym == wgm_pkg::STAR_BYTE && lead_stars == pat_len)
                    lead_stars++;
                pat_len++;
            end else begin
                ovf_seen = 1'b1;
            end
            load_empty_row();
        end else begin
            if (first)
                load_empty_row();
            nxt = '0;
            for (j = 1; j <= pat_len; j++) begin
                if (pat_mem[j-1] == wgm_pkg::STAR_BYTE)
                    nxt[j] = nxt[j-1] | dp_row[j];
                else if (pat_mem[j-1] == wgm_pkg::ANY_BYTE || pat_mem[j-1] == sym)
                    nxt[j] = dp_row[j-1];
                else
                    nxt[j] = 1'b0;
            end
            dp_row = nxt;
        end
        v.matched  = dp_row[pat_len];
        v.overflow = ovf_seen;
        return v;
    endfunction

    // predict on input beats, check output beats; all sampled at the edge
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            pat_len    = 0;
            lead_stars = 0;
            ovf_seen   = 1'b0;
            load_empty_row();
            verdict_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result beat: tdata %02h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.matched) begin
                        $error("matched: expected %0d, got %0d", want.matched, m_tdata[0]);
                        mismatch_count++;
                    end
                    if (m_tdata[1] !== want.overflow) begin
                        $error("overflow: expected %0d, got %0d", want.overflow, m_tdata[1]);
                        mismatch_count++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $error("pad: expected 0, got %0h", m_tdata[7:2]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                verdict_q.push_back(glob_step(action_e'(s_tuser[0]), s_tdata, s_tuser[1]));
        end
    end

    // receiver back-pressure
    initial begin
        rx_mode_e mode;
        int       len;
        forever begin
            mode = rx_mode_e'($urandom_range(0, 3));
            len  = $urandom_range(4, 60);
            repeat (len) begin
                @(posedge aclk);
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                    default:   m_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    task automatic send_beat(action_e act, logic [7:0] sym, logic first);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= {first, act};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (verdict_q.size() != 0);
        @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_letter();
        return 8'(8'h61 + $urandom_range(0, 2));
    endfunction

    function automatic logic [7:0] pick_pattern_sym();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return wgm_pkg::STAR_BYTE;
        if (r < 5) return wgm_pkg::ANY_BYTE;
        if (r < 9) return pick_letter();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_sym();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return pick_letter();
        if (r == 7) return wgm_pkg::STAR_BYTE;
        if (r == 8) return wgm_pkg::ANY_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_empty_pattern();
        send_beat(ACT_TEXT, 8'h61, 1'b0);
        send_beat(ACT_TEXT, 8'h00, 1'b1);
        send_beat(ACT_PATTERN, wgm_pkg::STAR_BYTE, 1'b0);
        send_beat(ACT_TEXT, 8'hFF, 1'b1);
    endtask

    task automatic test_wildcards();
        send_beat(ACT_PATTERN, 8'hFF, 1'b1);
        send_beat(ACT_TEXT, 8'hFF, 1'b1);
        send_beat(ACT_TEXT, 8'h00, 1'b0);
        send_beat(ACT_PATTERN, 8'h61, 1'b1);
        send_beat(ACT_PATTERN, wgm_pkg::ANY_BYTE, 1'b0);
        send_beat(ACT_PATTERN, wgm_pkg::STAR_BYTE, 1'b0);
        send_beat(ACT_TEXT, wgm_pkg::STAR_BYTE, 1'b1);
        send_beat(ACT_TEXT, 8'h61, 1'b1);
        send_beat(ACT_TEXT, wgm_pkg::ANY_BYTE, 1'b0);
        send_beat(ACT_TEXT, wgm_pkg::STAR_BYTE, 1'b0);
        // wildcard pattern bytes stay wildcards against literal '*' text
        send_beat(ACT_PATTERN, wgm_pkg::STAR_BYTE, 1'b1);
        send_beat(ACT_PATTERN, wgm_pkg::STAR_BYTE, 1'b0);
        send_beat(ACT_PATTERN, 8'h78, 1'b0);
        send_beat(ACT_TEXT, wgm_pkg::STAR_BYTE, 1'b1);
        send_beat(ACT_TEXT, 8'h78, 1'b0);
        send_beat(ACT_TEXT, 8'h78, 1'b1);
        send_beat(ACT_TEXT, 8'h55, 1'b0);
    endtask

    task automatic test_store_full();
        int i;
        for (i = 0; i < MAXP; i++)
            send_beat(ACT_PATTERN, wgm_pkg::STAR_BYTE, i == 0);
        send_beat(ACT_PATTERN, 8'h61, 1'b0);
        send_beat(ACT_PATTERN, wgm_pkg::STAR_BYTE, 1'b0);
        send_beat(ACT_TEXT, 8'h7A, 1'b1);
        send_beat(ACT_TEXT, 8'hAA, 1'b0);
        wait_drained();
        send_beat(ACT_PATTERN, 8'h61, 1'b1);
        send_beat(ACT_TEXT, 8'h61, 1'b1);
    endtask

    task automatic test_random_globs(int goal);
        logic [7:0] pat_q [$];
        logic [7:0] txt_q [$];
        int         sent;
        int         plen;
        int         r;
        int         i;
        int         k;
        int         t;
        logic       pat_first;
        sent = 0;
        while (sent < goal) begin
            if ($urandom_range(0, 19) == 0)
                wait_drained();
            r = $urandom_range(0, 19);
            plen = (r < 16) ? $urandom_range(1, 10)
                 : (r < 19) ? $urandom_range(11, 40) : $urandom_range(60, 70);
            pat_first = ($urandom_range(0, 15) != 0);
            pat_q.delete();
            for (i = 0; i < plen; i++)
                pat_q.push_back(pick_pattern_sym());
            for (i = 0; i < plen; i++) begin
                send_beat(ACT_PATTERN, pat_q[i], (i == 0) ? pat_first : 1'b0);
                sent++;
            end
            for (t = $urandom_range(1, 3); t > 0; t--) begin
                txt_q.delete();
                if ($urandom_range(0, 9) < 7) begin
                    for (i = 0; i < plen && i < MAXP; i++) begin
                        if (pat_q[i] == wgm_pkg::STAR_BYTE) begin
                            repeat ($urandom_range(0, 3)) txt_q.push_back(pick_text_sym());
                        end else if (pat_q[i] == wgm_pkg::ANY_BYTE) begin
                            txt_q.push_back(pick_text_sym());
                        end else begin
                            txt_q.push_back(pat_q[i]);
                        end
                    end
                    if (txt_q.size() > 0 && $urandom_range(0, 9) < 3) begin
                        r = $urandom_range(0, 2);
                        if (r == 0)
                            txt_q[$urandom_range(0, txt_q.size() - 1)] = pick_text_sym();
                        else if (r == 1)
                            void'(txt_q.pop_back());
                        else
                            txt_q.push_back(pick_text_sym());
                    end
                end else begin
                    repeat ($urandom_range(1, 12)) txt_q.push_back(pick_text_sym());
                end
                for (k = 0; k < txt_q.size(); k++) begin
                    send_beat(ACT_TEXT, txt_q[k],
                              (k == 0) ? ($urandom_range(0, 9) != 0)
                                       : ($urandom_range(0, 40) == 0));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_pattern();
        test_wildcards();
        test_store_full();
        test_random_globs(1160);
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
